>>> rtl/phc_pkg.sv
// Shared constants for the half-plane polygon clip stage.
// Holds default widths and configuration register indexes; no dependencies.
`timescale 1ns / 1ps

package phc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 28;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_A_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_A_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_B_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_B_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_A  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_B  = 3'd6;

endpackage

>>> rtl/polygon_halfplane_clip_stage.sv
// Structure: an accepted edge passes five arithmetic stages, COORD_WIDTH multiply-divide
// stages and the output register before its first vertex shows on the output.
// Throughput: one edge a cycle while not stalled; an edge that yields two vertices
// holds the output register until both have gone, set by the single output port. The depth
// is fixed by the bit-serial multiply-divide, one bit of the coordinate difference per stage.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults:
// mode 0, sites at the origin, both weights 1.0.
`timescale 1ns / 1ps

module polygon_halfplane_clip_stage
    import phc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_prev_x,
    input  logic signed [COORD_WIDTH-1:0] i_prev_y,
    input  logic signed [COORD_WIDTH-1:0] i_cur_x,
    input  logic signed [COORD_WIDTH-1:0] i_cur_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic                          o_run_last
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    // The boundary function needs room for the doubled dot products and the shifted weights.
    localparam int FW = (2 * W + 6 > W + FRAC_BITS + 4) ? 2 * W + 6 : W + FRAC_BITS + 4;

    typedef struct packed {
        logic         valid;
        logic         ina;
        logic         inb;
        logic         negx;
        logic         negy;
        logic [W-1:0] ax;
        logic [W-1:0] ay;
        logic [W-1:0] bx;
        logic [W-1:0] by;
    } t_side;

    // Configuration registers.
    logic                r_clip_mode;
    logic signed [W-1:0] r_site_a_x, r_site_a_y, r_site_b_x, r_site_b_y;
    logic signed [W-1:0] r_weight_a, r_weight_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_mode <= 1'b0;
            r_site_a_x  <= '0;
            r_site_a_y  <= '0;
            r_site_b_x  <= '0;
            r_site_b_y  <= '0;
            r_weight_a  <= W'(1) << FRAC_BITS;
            r_weight_b  <= W'(1) << FRAC_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CLIP_MODE: r_clip_mode <= i_cfg_data[0];
                CFG_SITE_A_X:  r_site_a_x  <= i_cfg_data;
                CFG_SITE_A_Y:  r_site_a_y  <= i_cfg_data;
                CFG_SITE_B_X:  r_site_b_x  <= i_cfg_data;
                CFG_SITE_B_Y:  r_site_b_y  <= i_cfg_data;
                CFG_WEIGHT_A:  r_weight_a  <= i_cfg_data;
                CFG_WEIGHT_B:  r_weight_b  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The constant part of the power bisector, |Pi|^2 - |P0|^2 + (w0 - wi) scaled, is built
    // from the registers in two stages of its own. It is ready before an edge accepted just
    // after a register write reaches the stage that uses it.
    logic signed [2*W-1:0] r_sq_ax, r_sq_ay, r_sq_bx, r_sq_by;
    logic signed [FW-1:0]  r_cst;
    logic signed [FW-1:0]  pwr_a, pwr_b, wdiff;

    always_ff @(posedge i_clk) begin
        r_sq_ax <= (2*W)'(r_site_a_x) * (2*W)'(r_site_a_x);
        r_sq_ay <= (2*W)'(r_site_a_y) * (2*W)'(r_site_a_y);
        r_sq_bx <= (2*W)'(r_site_b_x) * (2*W)'(r_site_b_x);
        r_sq_by <= (2*W)'(r_site_b_y) * (2*W)'(r_site_b_y);
        r_cst   <= pwr_b - pwr_a + wdiff;
    end

    always_comb begin
        pwr_a = FW'(r_sq_ax) + FW'(r_sq_ay);
        pwr_b = FW'(r_sq_bx) + FW'(r_sq_by);
        wdiff = (FW'(r_weight_a) - FW'(r_weight_b)) <<< FRAC_BITS;
    end

    // Both modes reduce to f(X) = k * (p1*q1 + p2*q2) - c. In mode 0 p is X itself and q the
    // site difference, k = 2; in mode 1 p is X - u and q the line normal, k = 1, c = 0.
    logic signed [DW-1:0] q1, q2;

    always_comb begin
        if (r_clip_mode) begin
            q1 = DW'(r_site_a_y) - DW'(r_site_b_y);
            q2 = DW'(r_site_b_x) - DW'(r_site_a_x);
        end else begin
            q1 = DW'(r_site_b_x) - DW'(r_site_a_x);
            q2 = DW'(r_site_b_y) - DW'(r_site_a_y);
        end
    end

    // The whole pipeline moves as one: it advances whenever the output register can take
    // the item leaving the last stage.
    logic r_o_valid, r_p_valid;
    logic adv;

    assign adv     = !r_o_valid || (!i_stall && !r_p_valid);
    assign o_stall = !adv;

    // Stage 0: accepted edge and the p operands.
    logic                 r0_valid;
    logic signed [DW-1:0] r0_pa1, r0_pa2, r0_pb1, r0_pb2;
    logic [W-1:0]         r0_ax, r0_ay, r0_bx, r0_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (adv) begin
            r0_valid <= i_valid;
            r0_ax    <= i_prev_x;
            r0_ay    <= i_prev_y;
            r0_bx    <= i_cur_x;
            r0_by    <= i_cur_y;
            r0_pa1   <= DW'(i_prev_x) - (r_clip_mode ? DW'(r_site_a_x) : DW'(0));
            r0_pa2   <= DW'(i_prev_y) - (r_clip_mode ? DW'(r_site_a_y) : DW'(0));
            r0_pb1   <= DW'(i_cur_x) - (r_clip_mode ? DW'(r_site_a_x) : DW'(0));
            r0_pb2   <= DW'(i_cur_y) - (r_clip_mode ? DW'(r_site_a_y) : DW'(0));
        end
    end

    // Stage 1: the four products.
    logic                 r1_valid;
    logic signed [PW-1:0] r1_ma1, r1_ma2, r1_mb1, r1_mb2;
    logic [W-1:0]         r1_ax, r1_ay, r1_bx, r1_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= r0_valid;
            r1_ax    <= r0_ax;
            r1_ay    <= r0_ay;
            r1_bx    <= r0_bx;
            r1_by    <= r0_by;
            r1_ma1   <= PW'(r0_pa1) * PW'(q1);
            r1_ma2   <= PW'(r0_pa2) * PW'(q2);
            r1_mb1   <= PW'(r0_pb1) * PW'(q1);
            r1_mb2   <= PW'(r0_pb2) * PW'(q2);
        end
    end

    // Stage 2: boundary function at both vertices.
    logic                 r2_valid;
    logic signed [FW-1:0] r2_fa, r2_fb;
    logic [W-1:0]         r2_ax, r2_ay, r2_bx, r2_by;
    logic signed [PW:0]   sum_a, sum_b;
    logic signed [FW-1:0] f_a, f_b;

    always_comb begin
        sum_a = (PW+1)'(r1_ma1) + (PW+1)'(r1_ma2);
        sum_b = (PW+1)'(r1_mb1) + (PW+1)'(r1_mb2);
        if (r_clip_mode) begin
            f_a = FW'(sum_a);
            f_b = FW'(sum_b);
        end else begin
            f_a = (FW'(sum_a) <<< 1) - r_cst;
            f_b = (FW'(sum_b) <<< 1) - r_cst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= r1_valid;
            r2_ax    <= r1_ax;
            r2_ay    <= r1_ay;
            r2_bx    <= r1_bx;
            r2_by    <= r1_by;
            r2_fa    <= f_a;
            r2_fb    <= f_b;
        end
    end

    // Stage 3: inside flags, f(A) - f(B) and the coordinate differences.
    logic                 r3_valid, r3_ina, r3_inb;
    logic signed [FW-1:0] r3_fa, r3_dfr;
    logic signed [DW-1:0] r3_dx, r3_dy;
    logic [W-1:0]         r3_ax, r3_ay, r3_bx, r3_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (adv) begin
            r3_valid <= r2_valid;
            r3_ina   <= r2_fa[FW-1] || (r2_fa == '0);
            r3_inb   <= r2_fb[FW-1] || (r2_fb == '0);
            r3_fa    <= r2_fa;
            r3_dfr   <= r2_fa - r2_fb;
            r3_dx    <= DW'($signed(r2_bx)) - DW'($signed(r2_ax));
            r3_dy    <= DW'($signed(r2_by)) - DW'($signed(r2_ay));
            r3_ax    <= r2_ax;
            r3_ay    <= r2_ay;
            r3_bx    <= r2_bx;
            r3_by    <= r2_by;
        end
    end

    // Stage 4: a positive denominator, the matching numerator and the difference magnitudes.
    logic          r4_valid, r4_ina, r4_inb, r4_negx, r4_negy;
    logic [FW-1:0] r4_num, r4_den;
    logic [W-1:0]  r4_magx, r4_magy;
    logic [W-1:0]  r4_ax, r4_ay, r4_bx, r4_by;
    logic          den_neg;
    logic [DW-1:0] absx, absy;

    always_comb begin
        den_neg = r3_dfr[FW-1];
        absx    = r3_dx[DW-1] ? DW'(-r3_dx) : DW'(r3_dx);
        absy    = r3_dy[DW-1] ? DW'(-r3_dy) : DW'(r3_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (adv) begin
            r4_valid <= r3_valid;
            r4_ina   <= r3_ina;
            r4_inb   <= r3_inb;
            r4_num   <= den_neg ? FW'(-r3_fa) : FW'(r3_fa);
            r4_den   <= den_neg ? FW'(-r3_dfr) : FW'(r3_dfr);
            r4_negx  <= r3_dx[DW-1];
            r4_negy  <= r3_dy[DW-1];
            r4_magx  <= absx[W-1:0];
            r4_magy  <= absy[W-1:0];
            r4_ax    <= r3_ax;
            r4_ay    <= r3_ay;
            r4_bx    <= r3_bx;
            r4_by    <= r3_by;
        end
    end

    // Multiply-divide stages for x and y, with the rest of the edge carried alongside.
    logic [W-1:0]  qx, qy;
    logic [FW-1:0] remx, remy, denx, deny;

    phc_muldiv #(
        .MAG_W(W),
        .FW   (FW)
    ) u_div_x (
        .i_clk(i_clk),
        .i_en (adv),
        .i_num(r4_num),
        .i_den(r4_den),
        .i_mag(r4_magx),
        .o_q  (qx),
        .o_rem(remx),
        .o_den(denx)
    );

    phc_muldiv #(
        .MAG_W(W),
        .FW   (FW)
    ) u_div_y (
        .i_clk(i_clk),
        .i_en (adv),
        .i_num(r4_num),
        .i_den(r4_den),
        .i_mag(r4_magy),
        .o_q  (qy),
        .o_rem(remy),
        .o_den(deny)
    );

    t_side r_side [W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < W; i++) begin
                r_side[i].valid <= 1'b0;
            end
        end else if (adv) begin
            r_side[0] <= '{valid: r4_valid, ina: r4_ina, inb: r4_inb, negx: r4_negx,
                           negy: r4_negy, ax: r4_ax, ay: r4_ay, bx: r4_bx, by: r4_by};
            for (int i = 1; i < W; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Rounding to nearest with ties upward: for a positive offset add one when twice the
    // remainder reaches den; for a negative offset the quotient is -Q, less one when twice
    // the remainder exceeds den. -Q - r is formed as ~Q plus a carry of !r.
    t_side         tail;
    logic          rndx, rndy;
    logic [W-1:0]  cross_x, cross_y;

    always_comb begin
        tail    = r_side[W-1];
        rndx    = tail.negx ? ({remx, 1'b0} > {1'b0, denx}) : ({remx, 1'b0} >= {1'b0, denx});
        rndy    = tail.negy ? ({remy, 1'b0} > {1'b0, deny}) : ({remy, 1'b0} >= {1'b0, deny});
        cross_x = tail.ax + (tail.negx ? ~qx : qx) + W'(tail.negx ? !rndx : rndx);
        cross_y = tail.ay + (tail.negy ? ~qy : qy) + W'(tail.negy ? !rndy : rndy);
    end

    // Output register plus one pending vertex for an edge that enters the half-plane: the
    // crossing goes out first and B waits behind it.
    logic         r_o_last;
    logic [W-1:0] r_o_x, r_o_y, r_p_x, r_p_y;
    logic         n_o_valid, n_o_last, n_p_valid;
    logic [W-1:0] n_o_x, n_o_y, n_p_x, n_p_y;

    always_comb begin
        n_o_valid = r_o_valid;
        n_o_last  = r_o_last;
        n_o_x     = r_o_x;
        n_o_y     = r_o_y;
        n_p_valid = r_p_valid;
        n_p_x     = r_p_x;
        n_p_y     = r_p_y;
        if (r_o_valid && !i_stall && r_p_valid) begin
            n_o_last  = 1'b1;
            n_o_x     = r_p_x;
            n_o_y     = r_p_y;
            n_p_valid = 1'b0;
        end
        if (adv) begin
            n_o_valid = 1'b0;
            n_p_valid = 1'b0;
            if (tail.valid) begin
                case ({tail.ina, tail.inb})
                    2'b01: begin
                        n_o_valid = 1'b1;
                        n_o_last  = 1'b0;
                        n_o_x     = cross_x;
                        n_o_y     = cross_y;
                        n_p_valid = 1'b1;
                        n_p_x     = tail.bx;
                        n_p_y     = tail.by;
                    end
                    2'b11: begin
                        n_o_valid = 1'b1;
                        n_o_last  = 1'b1;
                        n_o_x     = tail.bx;
                        n_o_y     = tail.by;
                    end
                    2'b10: begin
                        n_o_valid = 1'b1;
                        n_o_last  = 1'b1;
                        n_o_x     = cross_x;
                        n_o_y     = cross_y;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_p_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
            r_p_valid <= n_p_valid;
        end
        r_o_last <= n_o_last;
        r_o_x    <= n_o_x;
        r_o_y    <= n_o_y;
        r_p_x    <= n_p_x;
        r_p_y    <= n_p_y;
    end

    assign o_valid    = r_o_valid;
    assign o_out_x    = r_o_x;
    assign o_out_y    = r_o_y;
    assign o_run_last = r_o_last;

`ifndef SYNTHESIS
    // A waiting vertex always sits behind a shown one.
    a_pend_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> r_o_valid)
        else $error("pending vertex without an output vertex");

    // A vertex that is not the last of its edge always has its successor waiting.
    a_not_last_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_run_last) |-> r_p_valid)
        else $error("non-final vertex with nothing behind it");

    // Once the crossing is taken, B follows at once as the last vertex of the edge.
    a_second_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && r_p_valid) |=> (o_valid && o_run_last))
        else $error("second vertex of an entering edge missing or not last");
`endif

endmodule

>>> rtl/phc_muldiv.sv
// Pipelined multiply-divide: quotient and remainder of num * mag / den, one bit of mag a stage.
// Depends on phc_pkg.
`timescale 1ns / 1ps

module phc_muldiv
    import phc_pkg::*;
#(
    parameter int MAG_W = COORD_WIDTH_DEF,
    parameter int FW    = 2 * COORD_WIDTH_DEF + 6
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [FW-1:0]    i_num,
    input  logic [FW-1:0]    i_den,
    input  logic [MAG_W-1:0] i_mag,
    output logic [MAG_W-1:0] o_q,
    output logic [FW-1:0]    o_rem,
    output logic [FW-1:0]    o_den
);

    logic [FW-1:0]    r_rem [MAG_W];
    logic [FW-1:0]    r_num [MAG_W];
    logic [FW-1:0]    r_den [MAG_W];
    logic [MAG_W-1:0] r_q   [MAG_W];
    logic [MAG_W-1:0] r_mag [MAG_W];

    for (genvar s = 0; s < MAG_W; s++) begin : g_step
        logic [FW-1:0]    rem_in;
        logic [FW-1:0]    num_in;
        logic [FW-1:0]    den_in;
        logic [MAG_W-1:0] q_in;
        logic [MAG_W-1:0] mag_in;
        logic [FW+1:0]    acc;
        logic [FW+1:0]    den1;
        logic [FW+1:0]    den2;
        logic [FW-1:0]    n_rem;
        logic [MAG_W-1:0] n_q;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign q_in   = '0;
            assign num_in = i_num;
            assign den_in = i_den;
            assign mag_in = i_mag;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign q_in   = r_q[s-1];
            assign num_in = r_num[s-1];
            assign den_in = r_den[s-1];
            assign mag_in = r_mag[s-1];
        end

        // The remainder stays below den, so the doubled remainder plus num stays below
        // three times den and one subtraction of den or of twice den brings it back.
        always_comb begin
            acc  = {1'b0, rem_in, 1'b0} + (mag_in[MAG_W-1] ? (FW+2)'(num_in) : '0);
            den1 = (FW+2)'(den_in);
            den2 = {1'b0, den_in, 1'b0};
            if (acc >= den2) begin
                n_rem = FW'(acc - den2);
                n_q   = (q_in << 1) + MAG_W'(2);
            end else if (acc >= den1) begin
                n_rem = FW'(acc - den1);
                n_q   = (q_in << 1) + MAG_W'(1);
            end else begin
                n_rem = FW'(acc);
                n_q   = q_in << 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_q[s]   <= n_q;
                r_num[s] <= num_in;
                r_den[s] <= den_in;
                r_mag[s] <= mag_in << 1;
            end
        end
    end

    assign o_q   = r_q[MAG_W-1];
    assign o_rem = r_rem[MAG_W-1];
    assign o_den = r_den[MAG_W-1];

endmodule

>>> bench/phc_clip_checker.sv
// Edge-clip checker: watches the configuration port and both item channels,
// predicts the emitted vertices and compares them. Depends on phc_pkg.
`timescale 1ns / 1ps

module phc_clip_checker
    import phc_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CW-1:0]        i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [CW-1:0]        i_prev_x,
    input  logic [CW-1:0]        i_prev_y,
    input  logic [CW-1:0]        i_cur_x,
    input  logic [CW-1:0]        i_cur_y,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [CW-1:0]        i_out_x,
    input  logic [CW-1:0]        i_out_y,
    input  logic                 i_run_last,
    output int                   o_errors,
    output int                   o_pending
);

    localparam int W = 256;
    typedef logic signed [W-1:0] t_wide;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
    } t_vertex;

    t_vertex vertex_q[$];

    logic                 mode;
    logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r, wa_r, wb_r;

    function automatic t_wide sx(logic signed [CW-1:0] v);
        t_wide r;
        r = v;
        return r;
    endfunction

    // Boundary value: a point is inside when this is zero or negative.
    function automatic t_wide boundary(t_wide x, t_wide y);
        t_wide ax, ay, bx, by;
        ax = sx(ax_r);
        ay = sx(ay_r);
        bx = sx(bx_r);
        by = sx(by_r);
        if (mode == 1'b0) begin
            return (((x * (bx - ax)) + (y * (by - ay))) <<< 1)
                   - ((bx * bx + by * by) - (ax * ax + ay * ay))
                   - ((sx(wa_r) - sx(wb_r)) <<< FB);
        end
        return (x - ax) * (ay - by) + (y - ay) * (bx - ax);
    endfunction

    // Crossing coordinate, rounded to nearest with ties upward (den > 0).
    function automatic logic [CW-1:0] crossing(t_wide a, t_wide b, t_wide num, t_wide den);
        t_wide n2, d2, q;
        n2 = ((num * (b - a)) <<< 1) + den;
        d2 = den <<< 1;
        q  = n2 / d2;
        if ((n2 % d2) != 0 && n2 < 0)
            q = q - 1;
        return CW'(a + q);
    endfunction

    task automatic predict_edge(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                logic signed [CW-1:0] cx, logic signed [CW-1:0] cy);
        t_wide   fa, fb, num, den;
        logic    a_in, b_in;
        t_vertex xing;
        t_vertex tip;
        fa   = boundary(sx(px), sx(py));
        fb   = boundary(sx(cx), sx(cy));
        a_in = (fa <= 0);
        b_in = (fb <= 0);
        xing = '0;
        if (a_in != b_in) begin
            num = fa;
            den = fa - fb;
            if (den < 0) begin
                num = -num;
                den = -den;
            end
            xing.x = crossing(sx(px), sx(cx), num, den);
            xing.y = crossing(sx(py), sx(cy), num, den);
        end
        if (b_in) begin
            if (!a_in) begin
                xing.last = 1'b0;
                vertex_q.insert(vertex_q.size(), xing);
            end
            tip = '{x: cx, y: cy, last: 1'b1};
            vertex_q.insert(vertex_q.size(), tip);
        end else if (a_in) begin
            xing.last = 1'b1;
            vertex_q.insert(vertex_q.size(), xing);
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_vertex want;
        if (!i_rst_n) begin
            mode = 1'b0;
            ax_r = '0;
            ay_r = '0;
            bx_r = '0;
            by_r = '0;
            wa_r = CW'(1) << FB;
            wb_r = CW'(1) << FB;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CLIP_MODE: mode = i_cfg_data[0];
                    CFG_SITE_A_X:  ax_r = i_cfg_data;
                    CFG_SITE_A_Y:  ay_r = i_cfg_data;
                    CFG_SITE_B_X:  bx_r = i_cfg_data;
                    CFG_SITE_B_Y:  by_r = i_cfg_data;
                    CFG_WEIGHT_A:  wa_r = i_cfg_data;
                    CFG_WEIGHT_B:  wb_r = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_edge(i_prev_x, i_prev_y, i_cur_x, i_cur_y);
            if (i_out_valid && !i_out_stall) begin
                if (vertex_q.size() == 0) begin
                    $error("vertex emitted with none expected: x=%h y=%h last=%b",
                           i_out_x, i_out_y, i_run_last);
                    o_errors++;
                end else begin
                    want = vertex_q.pop_front();
                    if (i_out_x !== want.x) begin
                        $error("out_x: expected %h, got %h", want.x, i_out_x);
                        o_errors++;
                    end
                    if (i_out_y !== want.y) begin
                        $error("out_y: expected %h, got %h", want.y, i_out_y);
                        o_errors++;
                    end
                    if (i_run_last !== want.last) begin
                        $error("run_last: expected %b, got %b", want.last, i_run_last);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = vertex_q.size();
    end

endmodule

>>> bench/polygon_halfplane_clip_stage_tb.sv
// Testbench top for the half-plane polygon clip stage: clock, reset, edge and
// configuration stimulus, stall patterns, watchdog and verdict. Depends on phc_pkg,
// phc_clip_checker and polygon_halfplane_clip_stage.
`timescale 1ns / 1ps

module polygon_halfplane_clip_stage_tb;
    import phc_pkg::*;

    localparam int CW       = COORD_WIDTH_DEF;
    localparam int FB       = FRAC_BITS_DEF;
    // Pipeline depth is CW + 6; drain a little beyond it before touching registers.
    localparam int DRAIN    = CW + 16;
    // Cycles without any item moving on either channel before the run is abandoned.
    localparam int WATCHDOG = 5000;
    localparam logic [CW-1:0] ONE   = CW'(1) << FB;
    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_CLIP_MODE;
    logic [CW-1:0]        i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [CW-1:0]        i_prev_x = '0, i_prev_y = '0, i_cur_x = '0, i_cur_y = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [CW-1:0]        o_out_x, o_out_y;
    logic                 o_run_last;

    int errors, pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet     = 0;

    always #5 i_clk = ~i_clk;

    polygon_halfplane_clip_stage #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_stall, .i_prev_x, .i_prev_y, .i_cur_x, .i_cur_y,
        .o_valid, .i_stall, .o_out_x, .o_out_y, .o_run_last
    );

    phc_clip_checker #(.CW(CW), .FB(FB)) u_check (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_prev_x, .i_prev_y, .i_cur_x, .i_cur_y,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_x(o_out_x), .i_out_y(o_out_y), .i_run_last(o_run_last),
        .o_errors(errors), .o_pending(pending)
    );

    // The receiver stalls at random, at the rate that the current phase sets.
    always @(negedge i_clk)
        i_stall = (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    // The watchdog is reset by any item moving on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_clip(logic m, logic [CW-1:0] ax, logic [CW-1:0] ay,
                             logic [CW-1:0] bx, logic [CW-1:0] by,
                             logic [CW-1:0] wa, logic [CW-1:0] wb);
        cfg_write(CFG_CLIP_MODE, CW'(m));
        cfg_write(CFG_SITE_A_X, ax);
        cfg_write(CFG_SITE_A_Y, ay);
        cfg_write(CFG_SITE_B_X, bx);
        cfg_write(CFG_SITE_B_Y, by);
        cfg_write(CFG_WEIGHT_A, wa);
        cfg_write(CFG_WEIGHT_B, wb);
    endtask

    // Wait for every expected vertex, then let the pipeline empty of edges that
    // produce nothing. The sender stays silent throughout.
    task automatic drain;
        i_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    // Offers one edge; returns at the falling edge after it has been taken, with
    // valid left high so that back-to-back items follow with no gap between them.
    task automatic send_edge(logic [CW-1:0] px, logic [CW-1:0] py,
                             logic [CW-1:0] cx, logic [CW-1:0] cy);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_prev_x = px;
        i_prev_y = py;
        i_cur_x  = cx;
        i_cur_y  = cy;
        do
            @(posedge i_clk);
        while (o_stall);
        @(negedge i_clk);
    endtask

    // Mostly moderate magnitudes so that crossings are common, with full-range
    // values and the two extremes mixed in.
    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(9))
            0, 1: return CW'($urandom);
            2:    return $urandom_range(1) ? C_MAX : C_MIN;
            default: return CW'($signed(CW'($urandom)) >>> $urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [CW-1:0] rand_weight(bit wild);
        if (wild && $urandom_range(3) == 0)
            return $urandom_range(1) ? C_MAX : C_MIN;
        return CW'($signed(CW'($urandom)) >>> $urandom_range(2, 12));
    endfunction

    // A closed polygon fed the way a clipper walks it: (last, first), then onward.
    task automatic send_polygon(output int sent);
        logic [CW-1:0] vx[8], vy[8];
        int n;
        n = $urandom_range(3, 8);
        for (int i = 0; i < n; i++) begin
            vx[i] = rand_coord();
            vy[i] = rand_coord();
        end
        for (int i = 0; i < n; i++)
            send_edge(vx[(i + n - 1) % n], vy[(i + n - 1) % n], vx[i], vy[i]);
        sent = n;
    endtask

    task automatic random_phase(int items);
        int done, n;
        done = 0;
        while (done < items) begin
            if ($urandom_range(4) == 0) begin
                send_edge(rand_coord(), rand_coord(), rand_coord(), rand_coord());
                done++;
            end else begin
                send_polygon(n);
                done += n;
            end
        end
        drain();
    endtask

    initial begin
        logic [CW-1:0] half;
        half = ONE >> 1;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset setting: coincident sites with equal weights, so every point is
        // inside and each edge yields only its end vertex.
        send_edge('0, '0, ONE, ONE);
        send_edge(C_MIN, C_MAX, C_MAX, C_MIN);
        drain();

        // Bisector of (0,0) and (1,0): inside is x <= 0.5. All four in/out cases,
        // a vertex exactly on the boundary and edges spanning the full range.
        load_clip(1'b0, '0, '0, ONE, '0, ONE, ONE);
        send_edge('0, '0, '0, ONE);
        send_edge('0, '0, ONE, ONE);
        send_edge(ONE, '0, '0, half);
        send_edge(ONE, '0, ONE << 1, ONE);
        send_edge(half, '0, ONE, '0);
        send_edge(ONE, ONE, half, '0);
        send_edge(C_MIN, C_MIN, C_MAX, C_MAX);
        send_edge(C_MAX, C_MIN, C_MIN, C_MAX);
        send_edge('0, '0, ONE + 1, 32'h1);
        drain();

        // Unequal and extreme weights shift the bisector far off.
        load_clip(1'b0, C_MIN, '0, C_MAX, ONE, C_MAX, C_MIN);
        send_edge(C_MIN, C_MIN, C_MAX, C_MAX);
        send_edge(C_MAX, '0, C_MIN, '0);
        send_edge('0, C_MAX, '0, C_MIN);
        drain();

        // Directed line from (0,0) up to (0,1): inside is the right side, x >= 0.
        load_clip(1'b1, '0, '0, '0, ONE, '0, '0);
        send_edge(-ONE, '0, -ONE, ONE);
        send_edge(-ONE, '0, ONE, ONE);
        send_edge(ONE, ONE, -ONE, '0);
        send_edge(ONE, '0, ONE, ONE);
        send_edge(C_MIN, C_MAX, C_MAX, C_MIN);
        drain();

        // Line with coincident end points: every point is on it, so all inside.
        load_clip(1'b1, ONE, ONE, ONE, ONE, '0, '0);
        send_edge(C_MIN, C_MIN, C_MAX, C_MAX);
        drain();

        // Random phases; each begins on an empty pipeline with a fresh setting.
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            i_stall = 1'b0;
            load_clip(p[0], rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_weight(p >= 4), rand_weight(p >= 4));
            random_phase(205);
        end

        idle_pct  = 0;
        stall_pct = 0;
        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
